FILE: design/field_square_p25519_macros.svh
// Assertion macros for the field squarer.
`ifndef FIELD_SQUARE_P25519_MACROS_SVH
`define FIELD_SQUARE_P25519_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define FSQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define FSQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

FILE: design/fsq_pkg.sv
package fsq_pkg;
  localparam int unsigned NumLimbs = 10;
  localparam int unsigned Stages = 4;
  localparam int unsigned InWidth = 28 * 5 + 27 * 5;
  localparam int unsigned InBytes = (InWidth + 7) / 8;
  localparam int unsigned OutWidth = 27 * 5 + 26 * 5 + 1;
  localparam int unsigned OutBytes = (OutWidth + 7) / 8;
  localparam longint EvenBound = 64'sd110729625;
  localparam longint OddBound = 64'sd55364812;
  typedef logic signed [63:0] word_t;
  typedef word_t limbs_t [NumLimbs];

  // One rounding carry step on limb k.
  function automatic limbs_t carry_step(limbs_t h, int unsigned k);
    limbs_t r;
    word_t c;
    int unsigned sh;
    r = h;
    sh = (k % 2 == 1) ? 25 : 26;
    c = (r[k] + (64'sd1 <<< (sh - 1))) >>> sh;
    r[k] = r[k] - (c <<< sh);
    if (k == 9) begin
      r[0] = r[0] + c * 64'sd19;
    end else begin
      r[k + 1] = r[k + 1] + c;
    end
    return r;
  endfunction
endpackage

FILE: design/field_square_p25519.sv
// Field squarer modulo 2^255-19, radix 2^25.5 limbs.
// Input channel s_axis_*: one transaction carries ten signed limbs, even
// limbs 28 bits and odd limbs 27 bits. Output channel m_axis_*: ten
// reduced limbs plus a bound error flag in tuser.
// The pipeline has four register stages: limb products, column sums,
// the first half of the carry chain, and the second half.
// A new transaction is accepted every cycle unless the output stalls.
// When the receiver holds tready low the whole pipeline freezes; nothing
// is dropped or repeated, and s_axis_tready drops only while the last
// stage holds a result.
// Reset clears the valid bits only; stale payload is never presented.
// The bound error flag is set when any input limb magnitude exceeds
// its allowed bound; the limbs are still computed with wrapping math.
`include "field_square_p25519_macros.svh"
module field_square_p25519 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // in_limb0..in_limb9 from the lowest bit up, then zero fill
  input  logic [fsq_pkg::InBytes*8-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // res_limb0..res_limb9 from the lowest bit up, then zero fill
  output logic [fsq_pkg::OutBytes*8-1:0]      m_axis_tdata,
  // bound_error
  output logic                                m_axis_tuser
);
  logic [fsq_pkg::Stages-1:0] vld_q, vld_d;
  logic en;
  fsq_pkg::word_t a [fsq_pkg::NumLimbs];
  logic err_d;
  logic [fsq_pkg::Stages-1:0] err_q;
  fsq_pkg::limbs_t h_s2, c_d, c_q, r_d, r_q;

  // Pipeline advances unless the output holds a result not yet taken.
  assign en = !(vld_q[fsq_pkg::Stages-1] && !m_axis_tready);
  assign s_axis_tready = en;

  always_comb begin
    int unsigned pos;
    pos = 0;
    err_d = 1'b0;
    for (int i = 0; i < fsq_pkg::NumLimbs; i++) begin
      if (i % 2 == 0) begin
        a[i] = 64'(signed'(s_axis_tdata[pos +: 28]));
        pos = pos + 28;
        if (a[i] > fsq_pkg::EvenBound || a[i] < -fsq_pkg::EvenBound) err_d = 1'b1;
      end else begin
        a[i] = 64'(signed'(s_axis_tdata[pos +: 27]));
        pos = pos + 27;
        if (a[i] > fsq_pkg::OddBound || a[i] < -fsq_pkg::OddBound) err_d = 1'b1;
      end
    end
  end

  fsq_products u_products (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (a),
    .h_o   (h_s2)
  );

  // Carry chain split in two halves of six steps each.
  always_comb begin
    c_d = h_s2;
    c_d = fsq_pkg::carry_step(c_d, 0);
    c_d = fsq_pkg::carry_step(c_d, 4);
    c_d = fsq_pkg::carry_step(c_d, 1);
    c_d = fsq_pkg::carry_step(c_d, 5);
    c_d = fsq_pkg::carry_step(c_d, 2);
    c_d = fsq_pkg::carry_step(c_d, 6);
    r_d = c_q;
    r_d = fsq_pkg::carry_step(r_d, 3);
    r_d = fsq_pkg::carry_step(r_d, 7);
    r_d = fsq_pkg::carry_step(r_d, 4);
    r_d = fsq_pkg::carry_step(r_d, 8);
    r_d = fsq_pkg::carry_step(r_d, 9);
    r_d = fsq_pkg::carry_step(r_d, 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= c_d;
      r_q <= r_d;
      err_q <= {err_q[fsq_pkg::Stages-2:0], err_d};
    end
  end

  assign vld_d = {vld_q[fsq_pkg::Stages-2:0], s_axis_tvalid};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_comb begin
    int unsigned pos;
    pos = 0;
    m_axis_tdata = '0;
    for (int i = 0; i < fsq_pkg::NumLimbs; i++) begin
      if (i % 2 == 0) begin
        m_axis_tdata[pos +: 27] = r_q[i][26:0];
        pos = pos + 27;
      end else begin
        m_axis_tdata[pos +: 26] = r_q[i][25:0];
        pos = pos + 26;
      end
    end
  end
  assign m_axis_tvalid = vld_q[fsq_pkg::Stages-1];
  assign m_axis_tuser = err_q[fsq_pkg::Stages-1];

  `FSQ_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni,
                  m_axis_tvalid && !m_axis_tready, !s_axis_tready,
                  "input accepted during output stall")
  `FSQ_ASSERT_NEXT(a_stall_holds_result, clk_i, rst_ni,
                   m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `FSQ_ASSERT_NEXT(a_no_stall_advance, clk_i, rst_ni, s_axis_tready,
                   vld_q[1] == $past(vld_q[0]), "valid bit lost in pipeline")
endmodule

FILE: design/fsq_products.sv
// Stages one and two: limb products, then column sums.
module fsq_products (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  fsq_pkg::word_t        a_i [fsq_pkg::NumLimbs],
  output fsq_pkg::limbs_t       h_o
);
  fsq_pkg::word_t p_d [fsq_pkg::NumLimbs][fsq_pkg::NumLimbs];
  fsq_pkg::word_t p_q [fsq_pkg::NumLimbs][fsq_pkg::NumLimbs];
  fsq_pkg::limbs_t h_d;

  // Each product a_i*a_j carries its weight factor: 2 for cross pairs,
  // 2 more for two odd limbs, 19 when it wraps past 2^255.
  // The limbs are sign-extended 28-bit values, so each product needs a
  // 28 by 28 multiplier only.
  always_comb begin
    logic signed [55:0] prod;
    prod = '0;
    for (int i = 0; i < fsq_pkg::NumLimbs; i++) begin
      for (int j = 0; j < fsq_pkg::NumLimbs; j++) begin
        p_d[i][j] = '0;
        if (j >= i) begin
          prod = $signed(a_i[i][27:0]) * $signed(a_i[j][27:0]);
          p_d[i][j] = 64'(prod);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= p_d;
  end

  always_comb begin
    for (int k = 0; k < fsq_pkg::NumLimbs; k++) h_d[k] = '0;
    for (int i = 0; i < fsq_pkg::NumLimbs; i++) begin
      for (int j = i; j < fsq_pkg::NumLimbs; j++) begin
        int unsigned col;
        fsq_pkg::word_t f;
        col = (i + j) % fsq_pkg::NumLimbs;
        f = (i == j) ? 64'sd1 : 64'sd2;
        if ((i % 2 == 1) && (j % 2 == 1)) f = f * 64'sd2;
        if (i + j >= fsq_pkg::NumLimbs) f = f * 64'sd19;
        h_d[col] = h_d[col] + p_q[i][j] * f;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) h_o <= h_d;
  end
endmodule
